// ----- src/eip_pkg.sv -----
// ----------------------------------------------------------------------------
// eip_pkg: shared types and codes for the eased position interpolator
// Command, phase and easing codes, payload types and the control and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package eip_pkg;

  typedef logic signed [15:0] deg_t;
  typedef logic        [15:0] dur_t;
  typedef logic        [31:0] ms_t;
  typedef logic        [1:0]  code_t;

  localparam code_t CMD_INIT   = 2'd0;
  localparam code_t CMD_START  = 2'd1;
  localparam code_t CMD_TICK   = 2'd2;
  localparam code_t CMD_CANCEL = 2'd3;

  localparam code_t PH_IDLE      = 2'd0;
  localparam code_t PH_MOVING    = 2'd1;
  localparam code_t PH_COMPLETE  = 2'd2;
  localparam code_t PH_CANCELLED = 2'd3;

  localparam code_t EASE_LINEAR = 2'd0;
  localparam code_t EASE_SMOOTH = 2'd1;
  localparam code_t EASE_DECEL  = 2'd2;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mul1;
    logic mul2;
    logic fin;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_calc;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/eip_if.sv -----
// ----------------------------------------------------------------------------
// eip_if: valid/ready channels of the eased position interpolator
// Command channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface eip_in_if;
  logic                valid;
  logic                ready;
  eip_pkg::code_t      command;
  eip_pkg::deg_t       start_deg;
  eip_pkg::deg_t       end_deg;
  eip_pkg::dur_t       duration_ms;
  eip_pkg::code_t      easing_mode;
  eip_pkg::ms_t        now_ms;

  modport source (output valid, command, start_deg, end_deg, duration_ms, easing_mode,
                  now_ms, input ready);
  modport sink   (input valid, command, start_deg, end_deg, duration_ms, easing_mode,
                  now_ms, output ready);
endinterface

interface eip_out_if;
  logic                valid;
  logic                ready;
  eip_pkg::deg_t       position;
  eip_pkg::code_t      motion_state;
  eip_pkg::deg_t       target_deg;

  modport source (output valid, position, motion_state, target_deg, input ready);
  modport sink   (input valid, position, motion_state, target_deg, output ready);
endinterface

// ----- src/eip_ctrl.sv -----
// ----------------------------------------------------------------------------
// eip_ctrl: sequencer of the eased position interpolator
// Takes a word; an interpolating tick runs the divider bit by bit, the two
// multiply steps and the final add. Each result goes to the output register.
// ----------------------------------------------------------------------------
module eip_ctrl #(
  parameter int FRACTION_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  eip_pkg::dp_status_t   status,
  output eip_pkg::ctrl_cmd_t    cmd
);
  import eip_pkg::*;

  localparam int        CW   = $clog2(FRACTION_BITS);
  localparam logic [CW-1:0] LAST = CW'(FRACTION_BITS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = status.need_calc ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = S_MUL1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- src/eip_dp.sv -----
// ----------------------------------------------------------------------------
// eip_dp: datapath of the eased position interpolator
// Motion state, restoring divider for progress, easing and interpolation
// multipliers, and the output register.
// ----------------------------------------------------------------------------
module eip_dp #(
  parameter int FRACTION_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  eip_in_if.sink               in_chan,
  eip_out_if.source            out_chan,
  input  eip_pkg::ctrl_cmd_t   cmd,
  output eip_pkg::dp_status_t  status
);
  import eip_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam logic [F:0]   ONE_C = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0] TWO_C = {1'b1, {(F + 1){1'b0}}};

  deg_t   cur_r, from_r, to_r;
  dur_t   dur_r;
  ms_t    start_r;
  code_t  curve_r, phase_r;

  logic [15:0]       rem_r;
  logic [F-1:0]      quo_r;
  logic [2*F+1:0]    prod1_r;
  logic signed [F+18:0] prod2_r;
  logic              out_valid_r;
  deg_t              out_pos_r, out_tgt_r;
  code_t             out_ph_r;

  ms_t    elapsed;
  logic   moving;
  logic   tick_done;

  assign elapsed   = in_chan.now_ms - start_r;
  assign moving    = (phase_r == PH_MOVING);
  assign tick_done = (elapsed >= {16'd0, dur_r});

  assign status.need_calc = (in_chan.command == CMD_TICK) && moving && !tick_done;
  assign status.out_free  = !out_valid_r || out_chan.ready;

  // divider step: quotient bit from shifted remainder
  logic [16:0] rem_sh;
  logic        q_bit;
  logic [16:0] rem_sub;

  assign rem_sh  = {rem_r, 1'b0};
  assign q_bit   = (rem_sh >= {1'b0, dur_r});
  assign rem_sub = rem_sh - {1'b0, dur_r};

  // shaping products
  logic [F-1:0]   p;
  logic [F:0]     inv;
  logic [F-1:0]   sq_op;
  logic [F-1:0]   mul_a;
  logic [F+1:0]   mul_b;
  logic [2*F+1:0] prod1_nxt;

  assign p     = quo_r;
  assign inv   = ONE_C - {1'b0, p};
  assign sq_op = p[F-1] ? inv[F-1:0] : p;

  always_comb begin
    if (curve_r == EASE_DECEL) begin
      mul_a = p;
      mul_b = TWO_C - {2'b00, p};
    end else begin
      mul_a = sq_op;
      mul_b = {2'b00, sq_op};
    end
  end

  assign prod1_nxt = {{(F + 2){1'b0}}, mul_a} * {{F{1'b0}}, mul_b};

  logic [F:0] sq2;
  logic [F:0] f;

  assign sq2 = prod1_r[F-1 +: F+1];

  always_comb begin
    case (curve_r)
      EASE_SMOOTH: f = p[F-1] ? (ONE_C - sq2) : sq2;
      EASE_DECEL:  f = prod1_r[F +: F+1];
      default:     f = {1'b0, p};
    endcase
  end

  logic signed [16:0]   diff;
  logic signed [F+18:0] prod2_nxt;
  logic        [F+18:0] bias;
  logic        [F+18:0] rounded;
  logic        [15:0]   pos_nxt;

  assign diff      = $signed({to_r[15], to_r}) - $signed({from_r[15], from_r});
  assign prod2_nxt = $signed({{(F + 2){diff[16]}}, diff}) * $signed({18'd0, f});
  // truncate toward zero: bias negative products before the shift
  assign bias      = prod2_r[F+18] ? {19'd0, {F{1'b1}}} : '0;
  assign rounded   = prod2_r + bias;
  assign pos_nxt   = from_r + rounded[F +: 16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      from_r  <= '0;
      to_r    <= '0;
      dur_r   <= '0;
      start_r <= '0;
      curve_r <= EASE_LINEAR;
      phase_r <= PH_IDLE;
    end else if (cmd.accept) begin
      case (in_chan.command)
        CMD_INIT: begin
          cur_r   <= in_chan.start_deg;
          from_r  <= in_chan.start_deg;
          to_r    <= in_chan.start_deg;
          phase_r <= PH_IDLE;
        end
        CMD_START: begin
          from_r  <= in_chan.start_deg;
          to_r    <= in_chan.end_deg;
          curve_r <= in_chan.easing_mode;
          if (in_chan.duration_ms == '0) begin
            cur_r   <= in_chan.end_deg;
            phase_r <= PH_COMPLETE;
          end else begin
            cur_r   <= in_chan.start_deg;
            dur_r   <= in_chan.duration_ms;
            start_r <= in_chan.now_ms;
            phase_r <= PH_MOVING;
          end
        end
        CMD_TICK: begin
          if (moving && tick_done) begin
            cur_r   <= to_r;
            phase_r <= PH_COMPLETE;
          end
        end
        default: begin
          if (moving) begin
            phase_r <= PH_CANCELLED;
          end
        end
      endcase
    end else if (cmd.fin) begin
      cur_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rem_r <= elapsed[15:0];
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
      quo_r <= {quo_r[F-2:0], q_bit};
    end
    if (cmd.mul1) begin
      prod1_r <= prod1_nxt;
    end
    if (cmd.mul2) begin
      prod2_r <= prod2_nxt;
    end
    if (cmd.out_load) begin
      out_pos_r <= cur_r;
      out_ph_r  <= phase_r;
      out_tgt_r <= to_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.position     = out_pos_r;
  assign out_chan.motion_state = out_ph_r;
  assign out_chan.target_deg   = out_tgt_r;

endmodule

// ----- src/eased_position_interpolator.sv -----
// ----------------------------------------------------------------------------
// eased_position_interpolator: servo joint trajectory generator
// Init, start, tick and cancel words; each gives one result word.
// ----------------------------------------------------------------------------
// A tick that interpolates runs the restoring divider, one progress bit per cycle,
//   then the two multiply steps and the final add; other words go straight to the
//   output register. No new word is taken until the result is loaded there.
// A new word is taken while the previous result waits in the output register.
// Reset (synchronous): positions, duration and time cleared, linear, idle.
module eased_position_interpolator #(
  parameter int FRACTION_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  eip_in_if.sink    in_chan,
  eip_out_if.source out_chan
);
  import eip_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       ready;

  assign in_chan.ready = ready;

  eip_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ready),
    .status   (status),
    .cmd      (cmd)
  );

  eip_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .status   (status)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath step at once");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an untaken word");

  a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul1 |=> cmd.mul2 ##1 cmd.fin)
    else $error("multiply steps out of order");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.mul1 || cmd.mul2 || cmd.fin) |-> !in_chan.ready)
    else $error("word taken while a tick is computing");

endmodule
